// ===== rtl/core/bpfp_pkg.sv =====
// Shared constants, types and the bytewise CRC-16 update for the position frame parser.
package bpfp_pkg;

	localparam logic [7:0]  SYNC_BYTE = 8'hFF;
	localparam logic [7:0]  TYPE_BYTE = 8'h47;
	localparam logic [15:0] ID_CM     = 16'h0001;
	localparam logic [15:0] ID_MM     = 16'h0011;
	localparam logic [7:0]  LEN_CM    = 8'h10;
	localparam logic [7:0]  LEN_MM    = 8'h16;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;

	localparam logic [4:0] OFS_SYNC   = 5'd0;
	localparam logic [4:0] OFS_TYPE   = 5'd1;
	localparam logic [4:0] OFS_ID_LO  = 5'd2;
	localparam logic [4:0] OFS_ID_HI  = 5'd3;
	localparam logic [4:0] OFS_LEN    = 5'd4;
	localparam logic [4:0] OFS_HEADER = 5'd5;

	localparam int COORD_COUNT = 12;
	localparam logic [4:0] COORD_FIRST = 5'd9;
	localparam logic [4:0] COORD_LAST  = 5'd20;
	localparam logic [5:0] FRAME_OVERHEAD = 6'd7;

	typedef logic [COORD_COUNT-1:0][7:0] coord_bytes_t;

	typedef struct packed {
		logic done;
		logic hi_res;
	} frame_status_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/beacon_position_frame_parser_unit.sv =====
// Top level of the position frame parser: input register, frame parser and result register.
// The parser takes one received byte per cycle and, for every frame whose header checks pass
// and whose CRC-16 residue is zero, delivers one item with X, Y and Z in millimetres and the
// format flag. A byte is registered on acceptance and processed from the input register, so a
// result is registered once the last byte of its frame is processed. The sustained rate is one
// byte per cycle while results are taken, as CRC and header checks are combinational; a result
// not taken holds the byte behind it in the input register until the result register is free.
module beacon_position_frame_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic               high_res
);
	import bpfp_pkg::*;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               step;
	frame_status_t      status;
	coord_bytes_t       coord_bytes;
	logic signed [31:0] x_mm;
	logic signed [31:0] y_mm;
	logic signed [31:0] z_mm;
	logic               out_valid_q;
	logic signed [31:0] pos_x_q;
	logic signed [31:0] pos_y_q;
	logic signed [31:0] pos_z_q;
	logic               high_res_q;

	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	bpfp_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rx_byte     (byte_s1),
		.status      (status),
		.coord_bytes (coord_bytes)
	);

	bpfp_coord u_coord (
		.coord_bytes (coord_bytes),
		.hi_res      (status.hi_res),
		.pos_x       (x_mm),
		.pos_y       (y_mm),
		.pos_z       (z_mm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && status.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && status.done) begin
			pos_x_q    <= x_mm;
			pos_y_q    <= y_mm;
			pos_z_q    <= z_mm;
			high_res_q <= status.hi_res;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign pos_z     = pos_z_q;
	assign high_res  = high_res_q;

endmodule

// ===== rtl/core/bpfp_parse.sv =====
// Header checks, CRC accumulation and coordinate byte capture for one received byte per step.
module bpfp_parse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             rx_byte,
	output bpfp_pkg::frame_status_t status,
	output bpfp_pkg::coord_bytes_t coord_bytes
);
	import bpfp_pkg::*;

	logic [4:0]   frame_offset_q;
	logic [7:0]   id_lo_q;
	logic         hi_res_q;
	logic [15:0]  crc_q;
	logic [4:0]   len_q;
	coord_bytes_t coord_q;

	logic         good;
	logic [15:0]  id;
	logic [15:0]  crc_next;
	logic [4:0]   ofs_next;
	logic         frame_end;
	logic [3:0]   coord_idx;
	logic         coord_wr;

	always_comb begin
		id   = {rx_byte, id_lo_q};
		good = 1'b1;
		case (frame_offset_q)
			OFS_SYNC:  good = (rx_byte == SYNC_BYTE);
			OFS_TYPE:  good = (rx_byte == TYPE_BYTE);
			OFS_ID_HI: good = (id == ID_CM) || (id == ID_MM);
			OFS_LEN:   good = (rx_byte == (hi_res_q ? LEN_MM : LEN_CM));
			default:   good = 1'b1;
		endcase
		crc_next  = crc16_byte((frame_offset_q == OFS_SYNC) ? CRC_INIT : crc_q, rx_byte);
		ofs_next  = frame_offset_q + 5'd1;
		frame_end = (ofs_next > OFS_HEADER) &&
			({1'b0, ofs_next} == FRAME_OVERHEAD + {1'b0, len_q});
		coord_idx = 4'(frame_offset_q - COORD_FIRST);
		coord_wr  = (frame_offset_q >= COORD_FIRST) && (frame_offset_q <= COORD_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_offset_q <= '0;
			hi_res_q       <= 1'b0;
			crc_q          <= CRC_INIT;
			len_q          <= '0;
		end else if (step) begin
			if (!good) begin
				frame_offset_q <= '0;
			end else begin
				crc_q          <= crc_next;
				frame_offset_q <= frame_end ? 5'd0 : ofs_next;
				if (frame_offset_q == OFS_ID_HI) begin
					hi_res_q <= (id == ID_MM);
				end
				if (frame_offset_q == OFS_LEN) begin
					len_q <= rx_byte[4:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && good) begin
			if (frame_offset_q == OFS_ID_LO) begin
				id_lo_q <= rx_byte;
			end
			if (coord_wr) begin
				coord_q[coord_idx] <= rx_byte;
			end
		end
	end

	assign status.done   = good && frame_end && (crc_next == 16'h0000);
	assign status.hi_res = hi_res_q;
	assign coord_bytes   = coord_q;

endmodule

// ===== rtl/core/bpfp_coord.sv =====
// Converts the captured coordinate bytes into signed millimetre values.
module bpfp_coord (
	input  bpfp_pkg::coord_bytes_t coord_bytes,
	input  logic                   hi_res,
	output logic signed [31:0]     pos_x,
	output logic signed [31:0]     pos_y,
	output logic signed [31:0]     pos_z
);
	import bpfp_pkg::*;

	logic signed [31:0] cm_ext [3];
	logic signed [31:0] cm_mm  [3];
	logic signed [31:0] mm_val [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cm_ext[k] = 32'(signed'({coord_bytes[2*k+1], coord_bytes[2*k]}));
			cm_mm[k]  = (cm_ext[k] <<< 3) + (cm_ext[k] <<< 1);
			mm_val[k] = signed'({coord_bytes[4*k+3], coord_bytes[4*k+2],
				coord_bytes[4*k+1], coord_bytes[4*k]});
		end
		pos_x = hi_res ? mm_val[0] : cm_mm[0];
		pos_y = hi_res ? mm_val[1] : cm_mm[1];
		pos_z = hi_res ? mm_val[2] : cm_mm[2];
	end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the position frame parser: byte stream in, decoded positions out.
module tb;
	import bpfp_pkg::*;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               hres;
	} fix_t;

	class pos_scoreboard;
		logic [4:0]  ofs;
		logic [7:0]  id_lo;
		logic        hres;
		logic [15:0] crc;
		logic [4:0]  plen;
		logic [7:0]  coord [COORD_COUNT];
		fix_t        fix_q[$];
		int          errors;

		function new();
			ofs = '0;
			id_lo = '0;
			hres = 1'b0;
			crc = CRC_INIT;
			plen = '0;
			foreach (coord[i]) coord[i] = '0;
			errors = 0;
		endfunction

		static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int i = 0; i < 8; i++) begin
				fb = c[0] ^ b[i];
				c = c >> 1;
				if (fb) c = c ^ CRC_POLY;
			end
			return c;
		endfunction

		function logic signed [31:0] cm_value(int k);
			logic signed [15:0] h;
			h = {coord[k+1], coord[k]};
			return h * 32'sd10;
		endfunction

		function logic signed [31:0] mm_value(int k);
			return {coord[k+3], coord[k+2], coord[k+1], coord[k]};
		endfunction

		function void note_byte(logic [7:0] b);
			logic        ok;
			logic [15:0] id;
			fix_t        f;
			id = '0;
			case (ofs)
				OFS_SYNC: ok = (b == SYNC_BYTE);
				OFS_TYPE: ok = (b == TYPE_BYTE);
				OFS_ID_HI: begin
					id = {b, id_lo};
					ok = (id == ID_CM) || (id == ID_MM);
				end
				OFS_LEN: ok = (b == (hres ? LEN_MM : LEN_CM));
				default: ok = 1'b1;
			endcase
			if (!ok) begin
				ofs = OFS_SYNC;
				return;
			end
			if (ofs == OFS_SYNC) crc = CRC_INIT;
			crc = crc_step(crc, b);
			if (ofs == OFS_ID_LO)
				id_lo = b;
			else if (ofs == OFS_ID_HI)
				hres = (id == ID_MM);
			else if (ofs == OFS_LEN)
				plen = b[4:0];
			else if (ofs >= COORD_FIRST && ofs <= COORD_LAST)
				coord[ofs - COORD_FIRST] = b;
			ofs = ofs + 5'd1;
			if (ofs > OFS_HEADER && int'(ofs) == 7 + int'(plen)) begin
				ofs = OFS_SYNC;
				if (crc == 16'h0000) begin
					f.hres = hres;
					if (hres) begin
						f.x = mm_value(0);
						f.y = mm_value(4);
						f.z = mm_value(8);
					end else begin
						f.x = cm_value(0);
						f.y = cm_value(2);
						f.z = cm_value(4);
					end
					fix_q.push_back(f);
				end
			end
		endfunction

		task report_mismatch(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_fix(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
				logic hr);
			fix_t e;
			if (fix_q.size() == 0) begin
				report_mismatch($sformatf("unexpected item x=%0d y=%0d z=%0d", x, y, z));
				return;
			end
			e = fix_q.pop_front();
			if (x !== e.x) report_mismatch($sformatf("pos_x got %0d want %0d", x, e.x));
			if (y !== e.y) report_mismatch($sformatf("pos_y got %0d want %0d", y, e.y));
			if (z !== e.z) report_mismatch($sformatf("pos_z got %0d want %0d", z, e.z));
			if (hr !== e.hres) report_mismatch($sformatf("high_res got %b want %b", hr, e.hres));
		endtask
	endclass

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 1720;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic               high_res;

	logic           hold_off = 1'b0;
	logic           pressure_go = 1'b0;
	int             idle_pct = 0;
	int             stall_pct = 0;
	int             cycles = 0;
	int             sent = 0;
	logic [7:0]     wire_bytes[$];
	pos_scoreboard  sb;

	beacon_position_frame_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.high_res(high_res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL beacon_position_frame_parser_unit");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_fix(pos_x, pos_y, pos_z, high_res);
		if (!arst_n || hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		@(posedge pressure_go);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	task send_byte(logic [7:0] b);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_byte(b);
		sent++;
	endtask

	task drain_bytes();
		while (wire_bytes.size() != 0) send_byte(wire_bytes.pop_front());
	endtask

	function logic [31:0] pick_word(bit wide);
		logic [31:0] w;
		case ($urandom_range(7))
			0: w = 32'h0;
			1: w = wide ? 32'h7FFF_FFFF : 32'h0000_7FFF;
			2: w = wide ? 32'h8000_0000 : 32'h0000_8000;
			3: w = 32'hFFFF_FFFF;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	// damage: 0 keeps the frame intact, 1 flips one bit anywhere, 2 breaks off the frame early.
	task add_frame(bit hr, int damage, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		logic [7:0]  f[$];
		logic [15:0] id;
		logic [15:0] c;
		logic [31:0] w [3];
		int          plen;
		int          pos;
		int          bitpos;
		id = hr ? ID_MM : ID_CM;
		plen = hr ? int'(LEN_MM) : int'(LEN_CM);
		w[0] = x;
		w[1] = y;
		w[2] = z;
		f = {SYNC_BYTE, TYPE_BYTE, id[7:0], id[15:8], hr ? LEN_MM : LEN_CM};
		for (int i = 0; i < plen; i++) f.push_back(8'($urandom));
		for (int k = 0; k < 3; k++) begin
			if (hr) begin
				for (int j = 0; j < 4; j++) f[COORD_FIRST + 4 * k + j] = w[k][8 * j +: 8];
			end else begin
				for (int j = 0; j < 2; j++) f[COORD_FIRST + 2 * k + j] = w[k][8 * j +: 8];
			end
		end
		c = CRC_INIT;
		foreach (f[i]) c = pos_scoreboard::crc_step(c, f[i]);
		f.push_back(c[7:0]);
		f.push_back(c[15:8]);
		if (damage == 1) begin
			pos = $urandom_range(f.size() - 1);
			bitpos = $urandom_range(7);
			f[pos][bitpos] = ~f[pos][bitpos];
		end else if (damage == 2) begin
			f = f[0:$urandom_range(f.size() - 2)];
		end
		foreach (f[i]) wire_bytes.push_back(f[i]);
	endtask

	task add_random_frame();
		bit hr;
		int r;
		int damage;
		hr = $urandom_range(1);
		r = $urandom_range(99);
		damage = (r < 82) ? 0 : (r < 92) ? 1 : 2;
		add_frame(hr, damage, pick_word(hr), pick_word(hr), pick_word(hr));
	endtask

	task add_noise();
		int n;
		n = $urandom_range(1, 6);
		if ($urandom_range(2) == 0) begin
			wire_bytes.push_back(SYNC_BYTE);
			if ($urandom_range(1)) wire_bytes.push_back(TYPE_BYTE);
		end
		repeat (n) wire_bytes.push_back(8'($urandom));
	endtask

	task run_random(int target);
		while (sent < target) begin
			if ($urandom_range(99) < 80) add_random_frame();
			else add_noise();
			drain_bytes();
		end
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_frame(1'b0, 0, 32'h7FFF, 32'h8000, 32'hFFFF);
		add_frame(1'b1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		add_frame(1'b0, 1, 32'h1234, 32'h5678, 32'h9ABC);
		wire_bytes = {wire_bytes, 8'h00, SYNC_BYTE, 8'h48};
		wire_bytes = {wire_bytes, SYNC_BYTE, TYPE_BYTE, 8'h01, 8'h01};
		wire_bytes = {wire_bytes, SYNC_BYTE, TYPE_BYTE, 8'h00, 8'h00};
		wire_bytes = {wire_bytes, SYNC_BYTE, TYPE_BYTE, 8'h01, 8'h00, LEN_MM};
		wire_bytes = {wire_bytes, SYNC_BYTE, TYPE_BYTE, 8'h11, 8'h00, LEN_CM};
		wire_bytes.push_back(SYNC_BYTE);
		add_frame(1'b1, 0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
		add_frame(1'b0, 0, 32'h0, 32'h0001, 32'h7FFF);
		drain_bytes();

		pressure_go <= 1'b1;
		idle_pct = 0;
		stall_pct = 0;
		run_random(sent + RANDOM_BYTES / 4);
		idle_pct = 75;
		stall_pct = 0;
		run_random(sent + RANDOM_BYTES / 4);
		idle_pct = 0;
		stall_pct = 75;
		run_random(sent + RANDOM_BYTES / 4);
		idle_pct = 9;
		stall_pct = 9;
		run_random(sent + RANDOM_BYTES / 4);
		in_valid <= 1'b0;

		while (sb.fix_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS beacon_position_frame_parser_unit");
		else
			$display("FAIL beacon_position_frame_parser_unit");
		$finish;
	end
endmodule

// ===== beacon_position_frame_parser_unit.f =====
rtl/core/bpfp_pkg.sv
rtl/core/bpfp_parse.sv
rtl/core/bpfp_coord.sv
rtl/core/beacon_position_frame_parser_unit.sv
tb/tb.sv
